// ===== rtl/ssr_pkg.sv =====
// Package for the streaming substring replace block: sizes, codes, payload
// types and the control structs passed to the window and burst cells.
// No dependencies.
package ssr_pkg;

    localparam int PATTERN_MAX     = 16;
    localparam int REPLACEMENT_MAX = 16;
    localparam int WIN_CELLS       = PATTERN_MAX;
    localparam int BURST_CELLS     = (PATTERN_MAX > REPLACEMENT_MAX) ? PATTERN_MAX
                                                                     : REPLACEMENT_MAX;
    localparam int LEN_W           = 5;
    localparam int FILL_W          = 4;
    localparam int CNT_W           = 5;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 64;

    typedef logic [7:0] byte_t;

    localparam byte_t NEWLINE_BYTE = 8'd10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LOW      = 3'd0,
        CFG_PATTERN_HIGH     = 3'd1,
        CFG_PATTERN_LENGTH   = 3'd2,
        CFG_REPLACEMENT_LOW  = 3'd3,
        CFG_REPLACEMENT_HIGH = 3'd4,
        CFG_REPLACEMENT_LEN  = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic en;
        logic shift;
    } win_ctrl_t;

    typedef struct packed {
        logic load;
        logic shift;
    } burst_ctrl_t;

endpackage

// ===== rtl/stream_substring_replace.sv =====
// Top level of the streaming find-and-replace block: config registers, fill
// control, a row of window cells and a row of burst cells feeding the output.
// Depends on ssr_pkg, ssr_window_cell, ssr_burst_cell.
//
// channel | signals                                  | direction
// --------+------------------------------------------+----------
// in      | in_valid, in_ready, in_byte, end_of_stream | sink
// out     | out_valid, out_ready, out_byte, run_last,  | source
//         | stream_done                                |
// cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data  | sink
//
// An item is decided in the cycle it is accepted; its results (0 to 16 bytes)
// are loaded into the burst line and leave one per cycle while out_ready is
// high, from the next cycle. A new item is taken while the last byte of the
// previous one is taken, so items that yield at most one byte flow at one
// item per cycle while out_ready is high; an item with more bytes holds the
// input until its last byte is taken, since the single output port carries them.
// Reset clears the config registers, window fill and burst count.
// cfg_ready is always high; writes are expected only while the block is idle.
module stream_substring_replace (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  ssr_pkg::byte_t                       in_byte,
    input  logic                                 end_of_stream,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output ssr_pkg::byte_t                       out_byte,
    output logic                                 run_last,
    output logic                                 stream_done,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ssr_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ssr_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import ssr_pkg::*;

    logic [63:0]       pattern_low_reg;
    logic [63:0]       pattern_high_reg;
    logic [LEN_W-1:0]  pattern_length_reg;
    logic [63:0]       replacement_low_reg;
    logic [63:0]       replacement_high_reg;
    logic [LEN_W-1:0]  replacement_length_reg;

    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              eos_reg;

    logic [LEN_W-1:0]  plen;
    logic [LEN_W-1:0]  rlen;
    logic [LEN_W-1:0]  fill_inc;
    logic              in_acc;
    logic              out_acc;
    logic              cfg_acc;
    logic              pass_thru;
    logic              is_newline;
    logic              normal;
    logic              full;
    logic              hit;
    logic              use_rep;
    logic [CNT_W-1:0]  emit_cnt;

    byte_t             win_val  [WIN_CELLS+1];
    logic [WIN_CELLS-1:0] win_eq;
    byte_t             burst_q  [BURST_CELLS+1];
    win_ctrl_t         win_ctrl;
    burst_ctrl_t       burst_ctrl;

    assign cfg_ready = 1'b1;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign in_ready  = (count_reg == '0) || ((count_reg == CNT_W'(1)) && out_ready);
    assign in_acc    = in_valid && in_ready;
    assign out_valid = (count_reg != '0);
    assign out_acc   = out_valid && out_ready;
    assign out_byte  = burst_q[0];
    assign run_last  = (count_reg == CNT_W'(1));
    assign stream_done = run_last && eos_reg;

    assign plen = (pattern_length_reg > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX)
                                                             : pattern_length_reg;
    assign rlen = (replacement_length_reg > LEN_W'(REPLACEMENT_MAX))
                  ? LEN_W'(REPLACEMENT_MAX) : replacement_length_reg;

    assign fill_inc   = LEN_W'(fill_reg) + LEN_W'(1);
    assign pass_thru  = (plen == '0);
    assign is_newline = (in_byte == NEWLINE_BYTE);
    assign normal     = !pass_thru && !is_newline;
    assign full       = (fill_inc == plen);
    assign hit        = &win_eq;
    assign use_rep    = normal && full && hit;

    assign win_ctrl.en    = in_acc;
    assign win_ctrl.shift = in_acc && normal && full && !hit;

    assign burst_ctrl.load  = in_acc;
    assign burst_ctrl.shift = out_acc;

    always_comb
    begin
        emit_cnt  = '0;
        fill_next = '0;
        if (pass_thru)
        begin
            emit_cnt = CNT_W'(1);
        end
        else if (is_newline)
        begin
            emit_cnt = CNT_W'(fill_inc);
        end
        else if (full)
        begin
            if (hit)
            begin
                emit_cnt = CNT_W'(rlen);
            end
            else if (end_of_stream)
            begin
                emit_cnt = CNT_W'(plen);
            end
            else
            begin
                emit_cnt  = CNT_W'(1);
                fill_next = FILL_W'(plen - LEN_W'(1));
            end
        end
        else if (end_of_stream)
        begin
            emit_cnt = CNT_W'(fill_inc);
        end
        else
        begin
            fill_next = FILL_W'(fill_inc);
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (in_acc)
        begin
            count_next = emit_cnt;
        end
        else if (out_acc)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg        <= '0;
            pattern_high_reg       <= '0;
            pattern_length_reg     <= '0;
            replacement_low_reg    <= '0;
            replacement_high_reg   <= '0;
            replacement_length_reg <= '0;
            fill_reg               <= '0;
            count_reg              <= '0;
            eos_reg                <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cfg_acc && (cfg_index == CFG_PATTERN_LENGTH))
            begin
                fill_reg <= '0;
            end
            else if (in_acc)
            begin
                fill_reg <= fill_next;
            end
            if (in_acc)
            begin
                eos_reg <= end_of_stream;
            end
            if (cfg_acc)
            begin
                case (cfg_index)
                    CFG_PATTERN_LOW:      pattern_low_reg      <= cfg_data;
                    CFG_PATTERN_HIGH:     pattern_high_reg     <= cfg_data;
                    CFG_PATTERN_LENGTH:   pattern_length_reg   <= cfg_data[LEN_W-1:0];
                    CFG_REPLACEMENT_LOW:  replacement_low_reg  <= cfg_data;
                    CFG_REPLACEMENT_HIGH: replacement_high_reg <= cfg_data;
                    CFG_REPLACEMENT_LEN:  replacement_length_reg <= cfg_data[LEN_W-1:0];
                    default:              ;
                endcase
            end
        end
    end

    assign win_val[WIN_CELLS]   = '0;
    assign burst_q[BURST_CELLS] = '0;

    for (genvar i = 0; i < WIN_CELLS; i++)
    begin : g_win
        byte_t pat_b;
        if (i < 8)
        begin : g_lo
            assign pat_b = pattern_low_reg[8*i +: 8];
        end
        else
        begin : g_hi
            assign pat_b = pattern_high_reg[8*(i-8) +: 8];
        end

        ssr_window_cell u_cell (
            .clk       (clk),
            .ctrl      (win_ctrl),
            .sel       (fill_reg == FILL_W'(i)),
            .in_use    (LEN_W'(i) < plen),
            .in_byte   (in_byte),
            .pat_byte  (pat_b),
            .right_val (win_val[i+1]),
            .val       (win_val[i]),
            .eq        (win_eq[i])
        );
    end

    for (genvar i = 0; i < BURST_CELLS; i++)
    begin : g_burst
        byte_t rep_b;
        byte_t win_b;
        if (i < 8)
        begin : g_lo
            assign rep_b = replacement_low_reg[8*i +: 8];
        end
        else
        begin : g_hi
            assign rep_b = replacement_high_reg[8*(i-8) +: 8];
        end
        if (i < WIN_CELLS)
        begin : g_win_src
            assign win_b = win_val[i];
        end
        else
        begin : g_no_src
            assign win_b = '0;
        end

        ssr_burst_cell u_cell (
            .clk        (clk),
            .ctrl       (burst_ctrl),
            .load_byte  (use_rep ? rep_b : win_b),
            .right_byte (burst_q[i+1]),
            .q          (burst_q[i])
        );
    end

    // input is held while more than one byte of a burst remains
    a_ready_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg > CNT_W'(1)) |-> !in_ready)
        else $error("input taken with burst still pending");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(BURST_CELLS))
        else $error("burst count beyond line length");

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == '0) || (LEN_W'(fill_reg) < plen))
        else $error("window fill not below pattern length");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_acc && run_last && !in_acc) |=> (count_reg == '0))
        else $error("burst did not drain after last byte");

    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> (count_reg == $past(emit_cnt)))
        else $error("burst count not loaded from item");

endmodule

// ===== rtl/ssr_window_cell.sv =====
// One byte of the match window: appends the incoming byte when selected,
// compares against its pattern byte and hands its value to the left neighbor.
// Depends on ssr_pkg.
module ssr_window_cell (
    input  logic              clk,
    input  ssr_pkg::win_ctrl_t ctrl,
    input  logic              sel,
    input  logic              in_use,
    input  ssr_pkg::byte_t    in_byte,
    input  ssr_pkg::byte_t    pat_byte,
    input  ssr_pkg::byte_t    right_val,
    output ssr_pkg::byte_t    val,
    output logic              eq
);
    import ssr_pkg::*;

    byte_t data_reg;
    byte_t data_next;

    // value as seen after this item's append
    assign val       = sel ? in_byte : data_reg;
    assign eq        = !in_use || (val == pat_byte);
    assign data_next = ctrl.shift ? right_val : val;

    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== rtl/ssr_burst_cell.sv =====
// One slot of the output burst line: loads a result byte or takes the byte
// of its right neighbor as the line drains toward the output.
// Depends on ssr_pkg.
module ssr_burst_cell (
    input  logic                 clk,
    input  ssr_pkg::burst_ctrl_t ctrl,
    input  ssr_pkg::byte_t       load_byte,
    input  ssr_pkg::byte_t       right_byte,
    output ssr_pkg::byte_t       q
);
    import ssr_pkg::*;

    byte_t q_reg;
    byte_t q_next;

    assign q_next = ctrl.load ? load_byte : right_byte;
    assign q      = q_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load || ctrl.shift)
        begin
            q_reg <= q_next;
        end
    end

endmodule
